// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the thermostat RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define STT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define STT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg
// Types, codes and constants for the soldering tip thermostat.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int COUNT_BITS  = 13;
   localparam int BAND_BITS   = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = {COUNT_BITS{1'b1}};

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLEEP_AFTER = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFF_AFTER   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLEEP_LEVEL = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAL_LOW     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAL_MID     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAL_HIGH    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_READY_BAND  = 3'd6;

   // register reset values
   localparam logic [COUNT_BITS-1:0]  RST_SLEEP_AFTER = COUNT_BITS'(3000);
   localparam logic [COUNT_BITS-1:0]  RST_OFF_AFTER   = COUNT_BITS'(6000);
   localparam logic [SAMPLE_BITS-1:0] RST_SLEEP_LEVEL = SAMPLE_BITS'(100);
   localparam logic [SAMPLE_BITS-1:0] RST_CAL_LOW     = SAMPLE_BITS'(118);
   localparam logic [SAMPLE_BITS-1:0] RST_CAL_MID     = SAMPLE_BITS'(221);
   localparam logic [SAMPLE_BITS-1:0] RST_CAL_HIGH    = SAMPLE_BITS'(324);
   localparam logic [BAND_BITS-1:0]   RST_READY_BAND  = BAND_BITS'(10);

   // LED and mode codes
   localparam logic [1:0] LED_RED   = 2'd0;
   localparam logic [1:0] LED_GREEN = 2'd1;
   localparam logic [1:0] LED_BOTH  = 2'd2;

   localparam logic [1:0] MODE_ACTIVE = 2'd0;
   localparam logic [1:0] MODE_SLEEP  = 2'd1;
   localparam logic [1:0] MODE_OFF    = 2'd2;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] tip_sample;
      logic [SAMPLE_BITS-1:0] knob_sample;
      logic                   handle_moved;
   } stt_req_type;

   typedef struct packed {
      logic                   heater_on;
      logic [1:0]             led_drive;
      logic [1:0]             run_mode;
      logic [SAMPLE_BITS-1:0] target_level;
      logic [SAMPLE_BITS-1:0] smoothed_level;
   } stt_rsp_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]  sleep_after;
      logic [COUNT_BITS-1:0]  off_after;
      logic [SAMPLE_BITS-1:0] sleep_level;
      logic [SAMPLE_BITS-1:0] cal_low;
      logic [SAMPLE_BITS-1:0] cal_mid;
      logic [SAMPLE_BITS-1:0] cal_high;
      logic [BAND_BITS-1:0]   ready_band;
   } stt_cfg_type;

   // one tick held in the input stage, setpoint already mapped
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] tip_sample;
      logic [SAMPLE_BITS-1:0] target;
      logic                   handle_moved;
   } stt_stage_type;

endpackage

`default_nettype wire

// ----- src/stt_setpoint.sv -----
// ----------------------------------------------------------------------------
// stt_setpoint
// Knob to setpoint mapping: two linear pieces through cal_low, cal_mid and
// cal_high, quotient truncated toward zero, result clamped to sample range.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_setpoint
   import stt_pkg::*;
(
   input  wire logic [SAMPLE_BITS-1:0] knob_sample,
   input  wire stt_cfg_type            cfg,
   output logic      [SAMPLE_BITS-1:0] target
);

   localparam int SB = SAMPLE_BITS;
   localparam logic [SB:0] SPAN  = (SB+1)'((1 << (SB-1)) - 1);
   localparam logic [SB:0] SPAN2 = (SB+1)'(2 * ((1 << (SB-1)) - 1));
   localparam logic [SB:0] SPAN3 = (SB+1)'(3 * ((1 << (SB-1)) - 1));

   logic                   upper;
   logic [SB-2:0]          pos;
   logic [SB-1:0]          lo_pt;
   logic [SB-1:0]          hi_pt;
   logic signed [SB:0]     diff;
   logic                   neg;
   logic [SB-1:0]          mag;
   logic [2*SB-2:0]        prod;
   logic [SB-1:0]          q0;
   logic [SB:0]            rem;
   logic [SB-1:0]          corr;
   logic [SB-1:0]          quo;
   logic signed [SB+1:0]   val;

   always_comb begin
      upper = knob_sample[SB-1];
      pos   = knob_sample[SB-2:0];
      lo_pt = upper ? cfg.cal_mid  : cfg.cal_low;
      hi_pt = upper ? cfg.cal_high : cfg.cal_mid;
      diff  = $signed({1'b0, hi_pt}) - $signed({1'b0, lo_pt});
      neg   = diff[SB];
      mag   = neg ? SB'(-diff) : SB'(diff);
      prod  = (2*SB-1)'(pos * mag);
      q0    = prod[2*SB-2:SB-1];

      // divide by 2^(SB-1)-1: remainder of the shift is low bits plus q0
      rem = {2'b00, prod[SB-2:0]} + {1'b0, q0};
      if (rem >= SPAN3) begin
         corr = SB'(3);
      end else if (rem >= SPAN2) begin
         corr = SB'(2);
      end else if (rem >= SPAN) begin
         corr = SB'(1);
      end else begin
         corr = '0;
      end
      quo = upper ? (q0 + corr) : q0;

      val = neg ? ($signed({2'b00, lo_pt}) - $signed({2'b00, quo}))
                : ($signed({2'b00, lo_pt}) + $signed({2'b00, quo}));
      if (val < 0) begin
         target = '0;
      end else if (val > $signed({2'b00, SAMPLE_MAX})) begin
         target = SAMPLE_MAX;
      end else begin
         target = val[SB-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- src/stt_core.sv -----
// ----------------------------------------------------------------------------
// stt_core
// Controller state and per-tick update: smoothing, heater decision, LED,
// idle counting and the active / sleep / off modes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stt_core
   import stt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step_en,
   input  wire stt_stage_type item,
   input  wire stt_cfg_type   cfg,
   output stt_rsp_type        result
);

   localparam int SB = SAMPLE_BITS;

   logic [SB-1:0]         smooth_ff,      smooth_in;
   logic                  primed_ff,      primed_in;
   logic [COUNT_BITS-1:0] idle_ff,        idle_in;
   logic                  sleeping_ff,    sleeping_in;
   logic                  led_level_ff,   led_level_in;
   logic [SB-1:0]         last_target_ff, last_target_in;

   logic [COUNT_BITS-1:0] idle_cur;
   logic [COUNT_BITS-1:0] idle_inc;
   logic                  asleep;
   logic [SB-1:0]         base;
   logic [SB+2:0]         acc;
   logic [SB-1:0]         sm;
   logic [SB:0]           band;
   logic                  green;

   always_comb begin
      idle_cur = item.handle_moved ? '0 : idle_ff;
      asleep   = item.handle_moved ? 1'b0 : sleeping_ff;
      idle_inc = (idle_cur == COUNT_MAX) ? idle_cur : idle_cur + 1'b1;

      base = primed_ff ? smooth_ff : item.tip_sample;
      acc  = ({3'b000, base} << 3) - {3'b000, base} + {3'b000, item.tip_sample};
      sm   = acc[SB+2:3];
      band = {{(SB+1-BAND_BITS){1'b0}}, cfg.ready_band};
      green = (({1'b0, sm} + band) > {1'b0, item.target}) &&
              (({1'b0, item.target} + band) > {1'b0, sm});

      smooth_in      = smooth_ff;
      primed_in      = primed_ff;
      idle_in        = idle_cur;
      sleeping_in    = asleep;
      led_level_in   = led_level_ff;
      last_target_in = last_target_ff;

      result.target_level = last_target_ff;

      if (!asleep) begin
         smooth_in      = sm;
         primed_in      = 1'b1;
         idle_in        = idle_inc;
         sleeping_in    = idle_cur > cfg.sleep_after;
         led_level_in   = green;
         last_target_in = item.target;
         result.heater_on    = sm < item.target;
         result.led_drive    = green ? LED_GREEN : LED_RED;
         result.run_mode     = MODE_ACTIVE;
         result.target_level = item.target;
      end else if (idle_cur < cfg.off_after) begin
         idle_in      = idle_inc;
         led_level_in = ~led_level_ff;
         result.heater_on = item.tip_sample < cfg.sleep_level;
         result.led_drive = led_level_ff ? LED_RED : LED_GREEN;
         result.run_mode  = MODE_SLEEP;
      end else begin
         result.heater_on = 1'b0;
         result.led_drive = LED_BOTH;
         result.run_mode  = MODE_OFF;
      end
      result.smoothed_level = smooth_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff      <= '0;
         primed_ff      <= 1'b0;
         idle_ff        <= '0;
         sleeping_ff    <= 1'b0;
         led_level_ff   <= 1'b0;
         last_target_ff <= '0;
      end else if (step_en) begin
         smooth_ff      <= smooth_in;
         primed_ff      <= primed_in;
         idle_ff        <= idle_in;
         sleeping_ff    <= sleeping_in;
         led_level_ff   <= led_level_in;
         last_target_ff <= last_target_in;
      end
   end

   `STT_ASSERT(a_primed_after_step, clock, reset, step_en |=> primed_ff, "not primed after tick")
   `STT_ASSERT(a_moved_restarts_idle, clock, reset, (step_en && item.handle_moved) |=> (idle_ff == COUNT_BITS'(1)), "movement did not restart idle count")
   `STT_ASSERT(a_smooth_held_idle, clock, reset, (step_en && result.run_mode != MODE_ACTIVE) |=> $stable(smooth_ff), "smoothed value moved outside active mode")

endmodule

`default_nettype wire

// ----- src/soldering_tip_thermostat_top.sv -----
// ----------------------------------------------------------------------------
// soldering_tip_thermostat_top
// Bang-bang tip temperature controller with idle sleep and shut-off.
// ----------------------------------------------------------------------------
//
//   channel | dir | ports                                  | beat
//   --------+-----+----------------------------------------+--------------------
//   req     | in  | req_valid, req_ready, req_data         | one control tick
//   rsp     | out | rsp_valid, rsp_ready, rsp_data         | one tick result
//   csr     | in  | csr_valid, csr_ready, csr_index, csr_data | one register write
//
// Two register stages: the input stage holds the tick with its setpoint already
// mapped from the knob, the output stage holds the result.
// One tick per cycle is sustained while rsp_ready stays high; the state update is
// a single pass. A full output stage with rsp_ready low stalls the input stage,
// then req_ready. Synchronous reset empties both stages, clears the controller
// state and loads the registers with their reset values. csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module soldering_tip_thermostat_top
   import stt_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire stt_req_type               req_data,

   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output stt_rsp_type                    rsp_data,

   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   stt_cfg_type   cfg_ff;
   stt_stage_type stage_ff, stage_in;
   logic          stage_valid_ff, stage_valid_in;
   stt_rsp_type   out_ff;
   logic          out_valid_ff;
   stt_rsp_type   core_rsp;
   logic [SAMPLE_BITS-1:0] knob_target;
   logic          req_fire;
   logic          advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sleep_after <= RST_SLEEP_AFTER;
         cfg_ff.off_after   <= RST_OFF_AFTER;
         cfg_ff.sleep_level <= RST_SLEEP_LEVEL;
         cfg_ff.cal_low     <= RST_CAL_LOW;
         cfg_ff.cal_mid     <= RST_CAL_MID;
         cfg_ff.cal_high    <= RST_CAL_HIGH;
         cfg_ff.ready_band  <= RST_READY_BAND;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SLEEP_AFTER: cfg_ff.sleep_after <= csr_data[COUNT_BITS-1:0];
            CSR_OFF_AFTER:   cfg_ff.off_after   <= csr_data[COUNT_BITS-1:0];
            CSR_SLEEP_LEVEL: cfg_ff.sleep_level <= csr_data[SAMPLE_BITS-1:0];
            CSR_CAL_LOW:     cfg_ff.cal_low     <= csr_data[SAMPLE_BITS-1:0];
            CSR_CAL_MID:     cfg_ff.cal_mid     <= csr_data[SAMPLE_BITS-1:0];
            CSR_CAL_HIGH:    cfg_ff.cal_high    <= csr_data[SAMPLE_BITS-1:0];
            CSR_READY_BAND:  cfg_ff.ready_band  <= csr_data[BAND_BITS-1:0];
            default: ;
         endcase
      end
   end

   stt_setpoint u_setpoint (
      .knob_sample (req_data.knob_sample),
      .cfg         (cfg_ff),
      .target      (knob_target)
   );

   // input stage moves on when the output stage is free or being drained
   assign advance   = stage_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      stage_valid_in = req_fire || (stage_valid_ff && !advance);
      stage_in       = stage_ff;
      if (req_fire) begin
         stage_in.tip_sample   = req_data.tip_sample;
         stage_in.target       = knob_target;
         stage_in.handle_moved = req_data.handle_moved;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   stt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (stage_ff),
      .cfg     (cfg_ff),
      .result  (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= core_rsp;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the soldering tip thermostat. A short table of
// directed ticks comes first, then randomized phases under changing register
// settings, then one unmoved run with sleep disabled. Every accepted tick is
// run through a local model of the controller, and each result beat is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
   import stt_pkg::*;
();

   localparam int KNOB_HALF    = 1 << (SAMPLE_BITS - 1);
   localparam int SETTLE_GAP   = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int PHASE_TICKS  = 160;
   localparam int SAT_TICKS    = 150;
   localparam int MAX_REPORTS  = 10;

   // index with no register behind it; writes are dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 3'd7;

   localparam stt_rsp_type NO_CHECK = '0;

   typedef struct packed {
      logic        setup;   // load the directed register set before this tick
      logic        fixed;   // use the typed-in result instead of the model
      stt_req_type item;
      stt_rsp_type want;
   } stim_row_type;

   localparam int DIR_ROWS = 17;
   localparam stim_row_type DIR_TABLE [DIR_ROWS] = '{
      // reset settings: first tick loads the smoother
      {1'b0, 1'b1, {10'd0,    10'd0,    1'b0}, {1'b1, LED_RED, MODE_ACTIVE, 10'd118, 10'd0}},
      {1'b0, 1'b1, {10'd1023, 10'd1023, 1'b1}, {1'b1, LED_RED, MODE_ACTIVE, 10'd324, 10'd127}},
      {1'b0, 1'b0, {10'd1023, 10'd512,  1'b0}, NO_CHECK},
      {1'b0, 1'b0, {10'd512,  10'd511,  1'b0}, NO_CHECK},
      {1'b0, 1'b0, {10'd300,  10'd700,  1'b0}, NO_CHECK},
      {1'b0, 1'b0, {10'd220,  10'd300,  1'b0}, NO_CHECK},
      // descending lower piece, short idle limits: active, sleep, off, wake
      {1'b1, 1'b0, {10'd0,    10'd0,    1'b1}, NO_CHECK},
      {1'b0, 1'b0, {10'd1023, 10'd511,  1'b0}, NO_CHECK},
      {1'b0, 1'b0, {10'd600,  10'd1023, 1'b0}, NO_CHECK},
      {1'b0, 1'b0, {10'd600,  10'd600,  1'b0}, NO_CHECK},
      {1'b0, 1'b0, {10'd0,    10'd5,    1'b0}, NO_CHECK},
      {1'b0, 1'b0, {10'd1023, 10'd5,    1'b0}, NO_CHECK},
      {1'b0, 1'b0, {10'd511,  10'd900,  1'b0}, NO_CHECK},
      {1'b0, 1'b0, {10'd0,    10'd900,  1'b0}, NO_CHECK},
      {1'b0, 1'b0, {10'd700,  10'd256,  1'b1}, NO_CHECK},
      {1'b0, 1'b0, {10'd700,  10'd768,  1'b0}, NO_CHECK},
      {1'b0, 1'b0, {10'd700,  10'd768,  1'b1}, NO_CHECK}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid;
   logic                      req_ready;
   stt_req_type               req_item;
   logic                      rsp_valid;
   logic                      rsp_ready;
   stt_rsp_type               rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   soldering_tip_thermostat_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // controller model state
   stt_cfg_type            regs;
   logic [SAMPLE_BITS-1:0] smooth_q;
   bit                     primed;
   logic [COUNT_BITS-1:0]  idle_cnt;
   bit                     asleep;
   bit                     blink;
   logic [SAMPLE_BITS-1:0] held_target;

   stt_rsp_type pending_results[$];
   int          bad_results = 0;
   int          cycle_count = 0;
   bit          hold_req = 1'b0;

   function automatic int knob_setpoint(logic [SAMPLE_BITS-1:0] knob);
      int pos, lo, hi, span, v;
      if (int'(knob) < KNOB_HALF) begin
         pos  = int'(knob);
         lo   = int'(regs.cal_low);
         hi   = int'(regs.cal_mid);
         span = KNOB_HALF;
      end else begin
         pos  = int'(knob) - KNOB_HALF;
         lo   = int'(regs.cal_mid);
         hi   = int'(regs.cal_high);
         span = KNOB_HALF - 1;
      end
      // signed divide truncates toward zero for falling calibrations
      v = pos * (hi - lo) / span + lo;
      if (v < 0) v = 0;
      if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
      return v;
   endfunction

   function automatic stt_rsp_type thermostat_tick(stt_req_type t);
      stt_rsp_type r;
      int sp, sm, band;
      r = '0;
      band = int'(regs.ready_band);
      if (t.handle_moved) begin
         idle_cnt = '0;
         asleep   = 1'b0;
      end
      if (!asleep) begin
         sp = knob_setpoint(t.knob_sample);
         if (!primed) begin
            smooth_q = t.tip_sample;
            primed   = 1'b1;
         end
         sm = (int'(smooth_q) * 7 + int'(t.tip_sample)) / 8;
         smooth_q    = SAMPLE_BITS'(sm);
         r.heater_on = (sm < sp);
         blink       = (sm + band > sp) && (sp + band > sm);
         r.led_drive = blink ? LED_GREEN : LED_RED;
         r.run_mode  = MODE_ACTIVE;
         held_target = SAMPLE_BITS'(sp);
         if (idle_cnt > regs.sleep_after) asleep = 1'b1;
         if (idle_cnt != COUNT_MAX) idle_cnt = idle_cnt + 1'b1;
      end else if (idle_cnt < regs.off_after) begin
         if (idle_cnt != COUNT_MAX) idle_cnt = idle_cnt + 1'b1;
         r.heater_on = (t.tip_sample < regs.sleep_level);
         blink       = !blink;
         r.led_drive = blink ? LED_GREEN : LED_RED;
         r.run_mode  = MODE_SLEEP;
      end else begin
         r.heater_on = 1'b0;
         r.led_drive = LED_BOTH;
         r.run_mode  = MODE_OFF;
      end
      r.target_level   = held_target;
      r.smoothed_level = smooth_q;
      return r;
   endfunction

   function automatic void apply_reg(logic [CSR_INDEX_BITS-1:0] idx,
                                     logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_SLEEP_AFTER: regs.sleep_after = data[COUNT_BITS-1:0];
         CSR_OFF_AFTER:   regs.off_after   = data[COUNT_BITS-1:0];
         CSR_SLEEP_LEVEL: regs.sleep_level = data[SAMPLE_BITS-1:0];
         CSR_CAL_LOW:     regs.cal_low     = data[SAMPLE_BITS-1:0];
         CSR_CAL_MID:     regs.cal_mid     = data[SAMPLE_BITS-1:0];
         CSR_CAL_HIGH:    regs.cal_high    = data[SAMPLE_BITS-1:0];
         CSR_READY_BAND:  regs.ready_band  = data[BAND_BITS-1:0];
         default: ;
      endcase
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int stall_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // unused upper data bits carry noise, the register keeps the low bits
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, int value);
      int w;
      logic [CSR_DATA_BITS-1:0] mask;
      logic [CSR_DATA_BITS-1:0] data;
      case (idx)
         CSR_SLEEP_AFTER, CSR_OFF_AFTER: w = COUNT_BITS;
         CSR_READY_BAND:                 w = BAND_BITS;
         CSR_SPARE:                      w = 0;
         default:                        w = SAMPLE_BITS;
      endcase
      mask = CSR_DATA_BITS'((1 << w) - 1);
      data = (CSR_DATA_BITS'($urandom) & ~mask) | (CSR_DATA_BITS'(value) & mask);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_regs(int sa, int oa, int sl, int lo, int mid, int hi, int band);
      write_reg(CSR_SLEEP_AFTER, sa);
      write_reg(CSR_OFF_AFTER, oa);
      write_reg(CSR_SLEEP_LEVEL, sl);
      write_reg(CSR_CAL_LOW, lo);
      write_reg(CSR_CAL_MID, mid);
      write_reg(CSR_CAL_HIGH, hi);
      write_reg(CSR_READY_BAND, band);
      write_reg(CSR_SPARE, $urandom);
   endtask

   task automatic push_tick(stt_req_type item, bit fixed, stt_rsp_type want, bit steady);
      stt_rsp_type pred;
      int gap;
      gap = steady ? 0 : idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (!req_ready);
      pred = thermostat_tick(item);
      pending_results.push_back(fixed ? want : pred);
   endtask

   // block is idle once every result is back and the pipe has drained
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_GAP) @(posedge clock);
   endtask

   task automatic run_phase(int count, int move_pct, bit steady);
      stt_req_type t;
      logic [SAMPLE_BITS-1:0] knob;
      int aim, r, i;
      knob = SAMPLE_BITS'($urandom);
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 8) knob = SAMPLE_BITS'($urandom);
         aim = knob_setpoint(knob);
         r = $urandom_range(0, 99);
         if (r < 10) begin
            t.tip_sample = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
         end else if (r < 65) begin
            // hover around the setpoint so the green band gets hit
            aim = aim + $urandom_range(0, 40) - 20;
            if (aim < 0) aim = 0;
            if (aim > int'(SAMPLE_MAX)) aim = int'(SAMPLE_MAX);
            t.tip_sample = SAMPLE_BITS'(aim);
         end else begin
            t.tip_sample = SAMPLE_BITS'($urandom);
         end
         t.knob_sample  = knob;
         t.handle_moved = ($urandom_range(0, 99) < move_pct);
         push_tick(t, 1'b0, NO_CHECK, steady);
      end
   endtask

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
            rsp_ready <= 1'b1;
         end else if (!reset && $urandom_range(0, 99) < 25) begin
            rsp_ready <= 1'b0;
            repeat (stall_len()) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      stt_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            bad_results++;
            if (bad_results <= MAX_REPORTS)
               $display("[%0d] unexpected result beat: %p", cycle_count, rsp_data);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.heater_on      !== want.heater_on      ||
                rsp_data.led_drive      !== want.led_drive      ||
                rsp_data.run_mode       !== want.run_mode       ||
                rsp_data.target_level   !== want.target_level   ||
                rsp_data.smoothed_level !== want.smoothed_level) begin
               bad_results++;
               if (bad_results <= MAX_REPORTS)
                  $display("[%0d] mismatch: expected %p, got %p", cycle_count, want, rsp_data);
            end
         end
      end
   end

   initial begin
      int ph, sa, oa;
      req_valid = 1'b0;
      req_item  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;

      regs = {RST_SLEEP_AFTER, RST_OFF_AFTER, RST_SLEEP_LEVEL, RST_CAL_LOW,
              RST_CAL_MID, RST_CAL_HIGH, RST_READY_BAND};
      smooth_q    = '0;
      primed      = 1'b0;
      idle_cnt    = '0;
      asleep      = 1'b0;
      blink       = 1'b0;
      held_target = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIR_TABLE[i]) begin
         if (DIR_TABLE[i].setup) begin
            settle();
            program_regs(2, 6, 512, 1023, 0, 1023, 40);
         end
         push_tick(DIR_TABLE[i].item, DIR_TABLE[i].fixed, DIR_TABLE[i].want, 1'b0);
      end

      for (ph = 0; ph < 8; ph++) begin
         settle();
         case (ph)
            0: program_regs(1, 1, 0, 0, 0, 0, 0);
            1: program_regs($urandom_range(1, 20), 8191, 1023, 1023, 1023, 1023, 255);
            default: begin
               sa = $urandom_range(1, 40);
               oa = $urandom_range(0, 3) == 0 ? $urandom_range(1, sa) : $urandom_range(1, 80);
               program_regs(sa, oa, $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 30));
            end
         endcase
         // let the output side sit still while ticks pile up behind it
         if (ph == 2) hold_req = 1'b1;
         run_phase(PHASE_TICKS, $urandom_range(1, 4), 1'b0);
      end

      // sleep disabled: an unmoved run stays active
      settle();
      program_regs(8191, $urandom_range(1, 8191), $urandom_range(0, 1023), 118, 221, 324, 10);
      push_tick('{tip_sample: 10'd200, knob_sample: 10'd400, handle_moved: 1'b1},
                1'b0, NO_CHECK, 1'b1);
      run_phase(SAT_TICKS, 0, 1'b1);
      push_tick('{tip_sample: 10'd200, knob_sample: 10'd400, handle_moved: 1'b1},
                1'b0, NO_CHECK, 1'b1);

      settle();
      if (bad_results == 0 && pending_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
